// File: rtl/core/tfn_pkg.sv
package tfn_pkg;

    // Fixed field widths
    localparam int COORD_W   = 32;
    localparam int NORM_W    = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_CFG   = 6;

    // Default fraction widths
    localparam int COORD_FRAC_BITS_DEF  = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // Internal datapath widths
    localparam int EDGE_W = 33;
    localparam int CR_W   = 63;
    localparam int ACC_W  = 66;
    localparam int SUM_W  = 62;
    localparam int LEN_W  = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COL0_XY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL0Z_COL1X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL1_YZ       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL2_XY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL2Z_TRANS_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_YZ      = 3'd5;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        64'd65536, 64'd0, 64'd65536, 64'd0, 64'd65536, 64'd0
    };

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_DEGEN      = 2'd1,
        STATUS_INCOMPLETE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_XF,
        PH_CROSS,
        PH_SQ
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_VERT,
        ST_EDGE,
        ST_ESHIFT,
        ST_CMAX,
        ST_CSHR,
        ST_CSHL,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/core/tfn_mul.sv
module tfn_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p
);

    logic signed [63:0] p_reg;

    // Register every product
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: rtl/core/tfn_sqrt.sv
module tfn_sqrt #(
    parameter int RAD_W = tfn_pkg::SUM_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     rad,
    output logic                 done,
    output logic [RAD_W/2-1:0]   root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [RAD_W-1:0] v_reg, v_next;
    logic [RAD_W-1:0] res_reg, res_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [RAD_W:0]   trial;

    // One result bit per cycle
    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            v_next    = rad;
            res_next  = '0;
            bit_next  = {2'b01, {(RAD_W-2){1'b0}}};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = v_reg - trial[RAD_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// File: rtl/core/tfn_div.sv
module tfn_div #(
    parameter int Q_W   = tfn_pkg::NORMAL_FRAC_BITS_DEF + 1,
    parameter int DEN_W = tfn_pkg::LEN_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DEN_W+Q_W-1:0]   num,
    input  logic [DEN_W-1:0]       den,
    output logic                   done,
    output logic [Q_W-1:0]         quo
);

    localparam int CNT_W = $clog2(Q_W);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   cand;
    logic             ge;

    // Restoring divide, one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cand      = {rem_reg, quo_reg[Q_W-1]};
        ge        = cand >= {1'b0, den_reg};
        if (start)
        begin
            rem_next  = num[DEN_W+Q_W-1:Q_W];
            quo_next  = num[Q_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = cand[DEN_W-1:0] - den_reg;
            end
            else
            begin
                rem_next = cand[DEN_W-1:0];
            end
            quo_next = {quo_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/core/triangle_transform_flat_normal.sv
// Vertex transform with flat face normal.
// Input channel (in_valid/in_ready) takes one vertex position (Q16.16) and a
// mesh_last flag. The position goes through the 3x3 matrix plus translation
// held in six 64-bit registers written over the cfg channel (always ready).
// Every third vertex closes a triangle: three requests leave on the output
// channel (out_valid/out_ready), the held positions first, each carrying the
// unit face normal in Q1.14 and a status. mesh_last on the first or second
// vertex of a triangle sends one incomplete request instead.
// Each vertex runs nine products through the shared multiplier, rounds
// each axis and is dispatched. The closing vertex adds edges and cross
// product, a shift loop, squares, a square root and three divides.
// in_ready is high only while the sequencer is idle.
// A result waits in the output register while out_ready is low; the next
// result is held back until it is taken, and the sequencer stalls there.
// Reset clears the sequencer, vertex count and output valid, and sets the
// matrix to identity with zero translation.
module triangle_transform_flat_normal #(
    parameter int COORD_FRAC_BITS  = tfn_pkg::COORD_FRAC_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [tfn_pkg::COORD_W-1:0] pos_x,
    input  logic signed [tfn_pkg::COORD_W-1:0] pos_y,
    input  logic signed [tfn_pkg::COORD_W-1:0] pos_z,
    input  logic                               mesh_last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [tfn_pkg::COORD_W-1:0] out_x,
    output logic signed [tfn_pkg::COORD_W-1:0] out_y,
    output logic signed [tfn_pkg::COORD_W-1:0] out_z,
    output logic signed [tfn_pkg::NORM_W-1:0]  norm_x,
    output logic signed [tfn_pkg::NORM_W-1:0]  norm_y,
    output logic signed [tfn_pkg::NORM_W-1:0]  norm_z,
    output logic [1:0]                         status,
    output logic                               triangle_end,
    output logic                               mesh_end,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tfn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfn_pkg::CFG_W-1:0]          cfg_data
);

    localparam int CW    = tfn_pkg::COORD_W;
    localparam int NW    = tfn_pkg::NORM_W;
    localparam int EW    = tfn_pkg::EDGE_W;
    localparam int RW    = tfn_pkg::CR_W;
    localparam int AW    = tfn_pkg::ACC_W;
    localparam int LW    = tfn_pkg::LEN_W;
    localparam int Q_W   = NORMAL_FRAC_BITS + 1;
    localparam int NUM_W = LW + Q_W;
    localparam logic signed [AW-1:0] HALF = AW'(64'd1 << (COORD_FRAC_BITS - 1));
    localparam logic signed [AW:0] SAT_MAX = 67'sd2147483647;
    localparam logic signed [AW:0] SAT_MIN = -67'sd2147483648;
    localparam logic [RW-1:0] HI_LIM = RW'(64'd1 << 30);
    localparam logic [RW-1:0] LO_LIM = RW'(64'd1 << 29);
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(32'd1 << NORMAL_FRAC_BITS);
    localparam logic [NW:0] NORM_CLAMP = 17'd32767;
    localparam logic signed [NW-1:0] NORM_MAX =
        (NORMAL_FRAC_BITS > 14) ? 16'sd32767 : NW'(32'd1 << NORMAL_FRAC_BITS);

    // Sequencer and datapath registers
    tfn_pkg::state_t  state_reg, state_next;
    tfn_pkg::phase_t  phase_reg, phase_next;
    tfn_pkg::status_t stat_reg, stat_next;
    logic [1:0]       comp_reg, comp_next;
    logic [1:0]       term_reg, term_next;
    logic [1:0]       vc_reg, vc_next;
    logic [1:0]       emit_reg, emit_next;
    logic             shr_done_reg, shr_done_next;
    logic             last_reg, last_next;
    logic signed [CW-1:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [CW-1:0] tpos_reg [3];
    logic signed [CW-1:0] tpos_next [3];
    logic signed [CW-1:0] held_x_reg [2];
    logic signed [CW-1:0] held_x_next [2];
    logic signed [CW-1:0] held_y_reg [2];
    logic signed [CW-1:0] held_y_next [2];
    logic signed [CW-1:0] held_z_reg [2];
    logic signed [CW-1:0] held_z_next [2];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [RW-1:0] cr_reg [3];
    logic signed [RW-1:0] cr_next [3];
    logic [RW-1:0]        m_reg, m_next;
    logic [LW-1:0]        len_reg, len_next;
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] n_next [3];
    logic [tfn_pkg::CFG_W-1:0] cfg_reg [tfn_pkg::NUM_CFG];

    logic                 out_valid_reg, out_valid_next;
    logic signed [CW-1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic signed [NW-1:0] onx_reg, onx_next, ony_reg, ony_next, onz_reg, onz_next;
    tfn_pkg::status_t     ost_reg, ost_next;
    logic                 otri_reg, otri_next, omesh_reg, omesh_next;

    // Shared unit hookup
    logic signed [CW-1:0]   mul_a, mul_b;
    logic signed [63:0]     mul_p;
    logic                   sqrt_start, sqrt_done;
    logic [LW-1:0]          sqrt_root;
    logic                   div_start, div_done;
    logic [NUM_W-1:0]       div_num;
    logic [Q_W-1:0]         div_quo;

    // Matrix view of the configuration
    logic signed [CW-1:0] mat [3][3];
    logic signed [CW-1:0] trans [3];
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] shd;
    logic signed [AW:0]   fsum;
    logic signed [CW-1:0] fin_val;
    logic [EW-1:0]        emag [6];
    logic [1:0]           esh;
    logic [RW-1:0]        cmag [3];
    logic [RW-1:0]        cr_max;
    logic [RW-1:0]        cur_mag;
    logic [Q_W-1:0]       q_lim;
    logic [NW:0]          q_ext;
    logic signed [NW-1:0] nval;
    logic [1:0]           i1, i2;

    assign in_ready  = (state_reg == tfn_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    tfn_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    tfn_sqrt #(
        .RAD_W (tfn_pkg::SUM_W)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (acc_reg[tfn_pkg::SUM_W-1:0]),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    tfn_div #(
        .Q_W   (Q_W),
        .DEN_W (LW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (len_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Unpack matrix entries
    always_comb
    begin
        mat[0][0] = cfg_reg[tfn_pkg::REG_COL0_XY][31:0];
        mat[0][1] = cfg_reg[tfn_pkg::REG_COL0Z_COL1X][63:32];
        mat[0][2] = cfg_reg[tfn_pkg::REG_COL2_XY][31:0];
        mat[1][0] = cfg_reg[tfn_pkg::REG_COL0_XY][63:32];
        mat[1][1] = cfg_reg[tfn_pkg::REG_COL1_YZ][31:0];
        mat[1][2] = cfg_reg[tfn_pkg::REG_COL2_XY][63:32];
        mat[2][0] = cfg_reg[tfn_pkg::REG_COL0Z_COL1X][31:0];
        mat[2][1] = cfg_reg[tfn_pkg::REG_COL1_YZ][63:32];
        mat[2][2] = cfg_reg[tfn_pkg::REG_COL2Z_TRANS_X][31:0];
        trans[0]  = cfg_reg[tfn_pkg::REG_COL2Z_TRANS_X][63:32];
        trans[1]  = cfg_reg[tfn_pkg::REG_TRANS_YZ][31:0];
        trans[2]  = cfg_reg[tfn_pkg::REG_TRANS_YZ][63:32];
    end

    // Select multiplier operands
    always_comb
    begin
        i1 = (comp_reg == 2'd0) ? 2'd1 : (comp_reg == 2'd1) ? 2'd2 : 2'd0;
        i2 = (comp_reg == 2'd0) ? 2'd2 : (comp_reg == 2'd1) ? 2'd0 : 2'd1;
        unique case (phase_reg)
            tfn_pkg::PH_XF:
            begin
                mul_a = mat[comp_reg][term_reg];
                mul_b = (term_reg == 2'd0) ? px_reg : (term_reg == 2'd1) ? py_reg : pz_reg;
            end
            tfn_pkg::PH_CROSS:
            begin
                mul_a = (term_reg == 2'd0) ? e1_reg[i1][CW-1:0] : e1_reg[i2][CW-1:0];
                mul_b = (term_reg == 2'd0) ? e2_reg[i2][CW-1:0] : e2_reg[i1][CW-1:0];
            end
            default:
            begin
                mul_a = cr_reg[comp_reg][CW-1:0];
                mul_b = cr_reg[comp_reg][CW-1:0];
            end
        endcase
    end

    // Rounding, translation, saturation; magnitudes and normal scaling
    always_comb
    begin
        prod_ext = {{(AW-64){mul_p[63]}}, mul_p};
        rnd      = acc_reg + HALF;
        shd      = rnd >>> COORD_FRAC_BITS;
        fsum     = {shd[AW-1], shd} + {{(AW+1-CW){trans[comp_reg][CW-1]}}, trans[comp_reg]};
        if (fsum > SAT_MAX)
        begin
            fin_val = 32'sh7fffffff;
        end
        else if (fsum < SAT_MIN)
        begin
            fin_val = 32'sh80000000;
        end
        else
        begin
            fin_val = fsum[CW-1:0];
        end

        for (int k = 0; k < 3; k++)
        begin
            emag[k]     = e1_reg[k][EW-1] ? EW'(-e1_reg[k]) : EW'(e1_reg[k]);
            emag[k + 3] = e2_reg[k][EW-1] ? EW'(-e2_reg[k]) : EW'(e2_reg[k]);
            cmag[k]     = cr_reg[k][RW-1] ? RW'(-cr_reg[k]) : RW'(cr_reg[k]);
        end
        esh = 2'd0;
        for (int k = 0; k < 6; k++)
        begin
            if (emag[k][32] || emag[k][31])
            begin
                esh = 2'd2;
            end
            else if (emag[k][30] && esh == 2'd0)
            begin
                esh = 2'd1;
            end
        end
        cr_max = (cmag[0] > cmag[1]) ? cmag[0] : cmag[1];
        cr_max = (cmag[2] > cr_max) ? cmag[2] : cr_max;

        cur_mag = cmag[comp_reg];
        div_num = NUM_W'({cur_mag[LW-1:0], {NORMAL_FRAC_BITS{1'b0}}})
                + NUM_W'(len_reg[LW-1:1]);
        q_lim   = (div_quo > Q_ONE) ? Q_ONE : div_quo;
        q_ext   = (NW+1)'(q_lim);
        if (q_ext > NORM_CLAMP)
        begin
            q_ext = NORM_CLAMP;
        end
        nval = cr_reg[comp_reg][RW-1] ? -$signed(q_ext[NW-1:0]) : $signed(q_ext[NW-1:0]);
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        stat_next     = stat_reg;
        comp_next     = comp_reg;
        term_next     = term_reg;
        vc_next       = vc_reg;
        emit_next     = emit_reg;
        shr_done_next = shr_done_reg;
        last_next     = last_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pz_next       = pz_reg;
        acc_next      = acc_reg;
        tpos_next     = tpos_reg;
        held_x_next   = held_x_reg;
        held_y_next   = held_y_reg;
        held_z_next   = held_z_reg;
        e1_next       = e1_reg;
        e2_next       = e2_reg;
        cr_next       = cr_reg;
        m_next        = m_reg;
        len_next      = len_reg;
        n_next        = n_reg;
        sqrt_start    = 1'b0;
        div_start     = 1'b0;

        out_valid_next = out_valid_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        onx_next       = onx_reg;
        ony_next       = ony_reg;
        onz_next       = onz_reg;
        ost_next       = ost_reg;
        otri_next      = otri_reg;
        omesh_next     = omesh_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tfn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    px_next    = pos_x;
                    py_next    = pos_y;
                    pz_next    = pos_z;
                    last_next  = mesh_last;
                    phase_next = tfn_pkg::PH_XF;
                    comp_next  = 2'd0;
                    term_next  = 2'd0;
                    state_next = tfn_pkg::ST_MUL;
                end
            end

            tfn_pkg::ST_MUL:
            begin
                state_next = tfn_pkg::ST_ACC;
            end

            tfn_pkg::ST_ACC:
            begin
                unique case (phase_reg)
                    tfn_pkg::PH_XF:
                    begin
                        acc_next = (term_reg == 2'd0) ? prod_ext : acc_reg + prod_ext;
                        if (term_reg == 2'd2)
                        begin
                            state_next = tfn_pkg::ST_FIN;
                        end
                        else
                        begin
                            term_next  = term_reg + 2'd1;
                            state_next = tfn_pkg::ST_MUL;
                        end
                    end
                    tfn_pkg::PH_CROSS:
                    begin
                        if (term_reg == 2'd0)
                        begin
                            acc_next   = prod_ext;
                            term_next  = 2'd1;
                            state_next = tfn_pkg::ST_MUL;
                        end
                        else
                        begin
                            cr_next[comp_reg] = acc_reg[RW-1:0] - mul_p[RW-1:0];
                            term_next         = 2'd0;
                            if (comp_reg == 2'd2)
                            begin
                                shr_done_next = 1'b0;
                                state_next    = tfn_pkg::ST_CMAX;
                            end
                            else
                            begin
                                comp_next  = comp_reg + 2'd1;
                                state_next = tfn_pkg::ST_MUL;
                            end
                        end
                    end
                    default:
                    begin
                        acc_next = (comp_reg == 2'd0) ? prod_ext : acc_reg + prod_ext;
                        if (comp_reg == 2'd2)
                        begin
                            state_next = tfn_pkg::ST_SQRT_GO;
                        end
                        else
                        begin
                            comp_next  = comp_reg + 2'd1;
                            state_next = tfn_pkg::ST_MUL;
                        end
                    end
                endcase
            end

            tfn_pkg::ST_FIN:
            begin
                tpos_next[comp_reg] = fin_val;
                if (comp_reg == 2'd2)
                begin
                    state_next = tfn_pkg::ST_VERT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    term_next  = 2'd0;
                    state_next = tfn_pkg::ST_MUL;
                end
            end

            tfn_pkg::ST_VERT:
            begin
                if (vc_reg != 2'd2)
                begin
                    held_x_next[vc_reg[0]] = tpos_reg[0];
                    held_y_next[vc_reg[0]] = tpos_reg[1];
                    held_z_next[vc_reg[0]] = tpos_reg[2];
                    if (last_reg)
                    begin
                        // Mesh ends mid-triangle: one incomplete request
                        vc_next    = 2'd0;
                        n_next     = '{default: '0};
                        stat_next  = tfn_pkg::STATUS_INCOMPLETE;
                        emit_next  = 2'd2;
                        state_next = tfn_pkg::ST_EMIT;
                    end
                    else
                    begin
                        vc_next    = vc_reg + 2'd1;
                        state_next = tfn_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    vc_next    = 2'd0;
                    state_next = tfn_pkg::ST_EDGE;
                end
            end

            tfn_pkg::ST_EDGE:
            begin
                e1_next[0] = EW'(held_x_reg[1]) - EW'(held_x_reg[0]);
                e1_next[1] = EW'(held_y_reg[1]) - EW'(held_y_reg[0]);
                e1_next[2] = EW'(held_z_reg[1]) - EW'(held_z_reg[0]);
                e2_next[0] = EW'(tpos_reg[0]) - EW'(held_x_reg[0]);
                e2_next[1] = EW'(tpos_reg[1]) - EW'(held_y_reg[0]);
                e2_next[2] = EW'(tpos_reg[2]) - EW'(held_z_reg[0]);
                state_next = tfn_pkg::ST_ESHIFT;
            end

            tfn_pkg::ST_ESHIFT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_next[k] = e1_reg[k] >>> esh;
                    e2_next[k] = e2_reg[k] >>> esh;
                end
                phase_next = tfn_pkg::PH_CROSS;
                comp_next  = 2'd0;
                term_next  = 2'd0;
                state_next = tfn_pkg::ST_MUL;
            end

            tfn_pkg::ST_CMAX:
            begin
                if (!shr_done_reg && cr_max == '0)
                begin
                    n_next     = '{default: '0};
                    stat_next  = tfn_pkg::STATUS_DEGEN;
                    emit_next  = 2'd0;
                    state_next = tfn_pkg::ST_EMIT;
                end
                else
                begin
                    m_next     = cr_max;
                    state_next = shr_done_reg ? tfn_pkg::ST_CSHL : tfn_pkg::ST_CSHR;
                end
            end

            tfn_pkg::ST_CSHR:
            begin
                if (m_reg >= HI_LIM)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        cr_next[k] = cr_reg[k] >>> 1;
                    end
                    m_next = m_reg >> 1;
                end
                else
                begin
                    shr_done_next = 1'b1;
                    state_next    = tfn_pkg::ST_CMAX;
                end
            end

            tfn_pkg::ST_CSHL:
            begin
                if (m_reg < LO_LIM)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        cr_next[k] = cr_reg[k] <<< 1;
                    end
                    m_next = m_reg << 1;
                end
                else
                begin
                    phase_next = tfn_pkg::PH_SQ;
                    comp_next  = 2'd0;
                    state_next = tfn_pkg::ST_MUL;
                end
            end

            tfn_pkg::ST_SQRT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = tfn_pkg::ST_SQRT_WAIT;
            end

            tfn_pkg::ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    len_next   = sqrt_root;
                    comp_next  = 2'd0;
                    state_next = tfn_pkg::ST_DIV_GO;
                end
            end

            tfn_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = tfn_pkg::ST_DIV_WAIT;
            end

            tfn_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    n_next[comp_reg] = nval;
                    if (comp_reg == 2'd2)
                    begin
                        stat_next  = tfn_pkg::STATUS_OK;
                        emit_next  = 2'd0;
                        state_next = tfn_pkg::ST_EMIT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = tfn_pkg::ST_DIV_GO;
                    end
                end
            end

            tfn_pkg::ST_EMIT:
            begin
                // Load the next request once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ox_next  = (emit_reg == 2'd0) ? held_x_reg[0] :
                               (emit_reg == 2'd1) ? held_x_reg[1] : tpos_reg[0];
                    oy_next  = (emit_reg == 2'd0) ? held_y_reg[0] :
                               (emit_reg == 2'd1) ? held_y_reg[1] : tpos_reg[1];
                    oz_next  = (emit_reg == 2'd0) ? held_z_reg[0] :
                               (emit_reg == 2'd1) ? held_z_reg[1] : tpos_reg[2];
                    onx_next   = n_reg[0];
                    ony_next   = n_reg[1];
                    onz_next   = n_reg[2];
                    ost_next   = stat_reg;
                    otri_next  = (emit_reg == 2'd2);
                    omesh_next = (emit_reg == 2'd2) && last_reg;
                    emit_next  = emit_reg + 2'd1;
                    if (emit_reg == 2'd2)
                    begin
                        state_next = tfn_pkg::ST_IDLE;
                    end
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfn_pkg::ST_IDLE;
            phase_reg     <= tfn_pkg::PH_XF;
            comp_reg      <= 2'd0;
            term_reg      <= 2'd0;
            vc_reg        <= 2'd0;
            emit_reg      <= 2'd0;
            shr_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            comp_reg      <= comp_next;
            term_reg      <= term_next;
            vc_reg        <= vc_next;
            emit_reg      <= emit_next;
            shr_done_reg  <= shr_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tfn_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_index < tfn_pkg::CFG_IDX_W'(tfn_pkg::NUM_CFG))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Datapath and output payload
    always_ff @(posedge clk)
    begin
        stat_reg   <= stat_next;
        last_reg   <= last_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pz_reg     <= pz_next;
        acc_reg    <= acc_next;
        tpos_reg   <= tpos_next;
        held_x_reg <= held_x_next;
        held_y_reg <= held_y_next;
        held_z_reg <= held_z_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        cr_reg     <= cr_next;
        m_reg      <= m_next;
        len_reg    <= len_next;
        n_reg      <= n_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oz_reg     <= oz_next;
        onx_reg    <= onx_next;
        ony_reg    <= ony_next;
        onz_reg    <= onz_next;
        ost_reg    <= ost_next;
        otri_reg   <= otri_next;
        omesh_reg  <= omesh_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;
    assign norm_x       = onx_reg;
    assign norm_y       = ony_reg;
    assign norm_z       = onz_reg;
    assign status       = ost_reg;
    assign triangle_end = otri_reg;
    assign mesh_end     = omesh_reg;

    // Checks
    a_vc_range: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg != 2'd3)
        else $error("vertex count out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    a_incomplete_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ost_reg == tfn_pkg::STATUS_INCOMPLETE
        |-> triangle_end && mesh_end && norm_x == '0 && norm_y == '0 && norm_z == '0)
        else $error("incomplete request with bad flags");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ost_reg == tfn_pkg::STATUS_DEGEN
        |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
        else $error("degenerate request with nonzero normal");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ost_reg == tfn_pkg::STATUS_OK
        |-> norm_x <= NORM_MAX && norm_x >= -NORM_MAX
            && norm_y <= NORM_MAX && norm_y >= -NORM_MAX
            && norm_z <= NORM_MAX && norm_z >= -NORM_MAX)
        else $error("normal component beyond unit length");

endmodule

// File: bench/triangle_transform_flat_normal_test.sv
module triangle_transform_flat_normal_test;
    import tfn_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int LONG_HOLD      = 400;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        status_t                   st;
        bit                        tri_end;
        bit                        mesh_fin;
    } vertex_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic mesh_last;
    logic out_valid;
    logic out_ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [1:0] status;
    logic triangle_end;
    logic mesh_end;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // predictor state
    logic [CFG_W-1:0] matrix_regs [NUM_CFG];
    longint pend_x [2];
    longint pend_y [2];
    longint pend_z [2];
    int unsigned corner_count;

    vertex_result_t expected_vertices [$];
    int mismatches;
    int idle_cycles;
    bit hold_request;
    bit no_gaps;

    triangle_transform_flat_normal dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .mesh_last(mesh_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .status(status), .triangle_end(triangle_end), .mesh_end(mesh_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic longint matrix_entry(int r, bit upper);
        logic signed [31:0] w;
        w = upper ? matrix_regs[r][63:32] : matrix_regs[r][31:0];
        return w;
    endfunction

    // round the summed products to the coordinate grid, then add translation and saturate
    function automatic longint apply_row(longint a, longint x, longint b, longint y,
                                         longint c, longint z, longint t);
        logic signed [127:0] acc;
        logic signed [127:0] w1, w2, w3;
        w1 = a; w2 = b; w3 = c;
        acc = w1 * x + w2 * y + w3 * z;
        acc = (acc + (128'sd1 <<< 15)) >>> 16;
        acc = acc + t;
        if (acc > 128'sd2147483647) return 64'sd2147483647;
        if (acc < -128'sd2147483648) return -64'sd2147483648;
        return longint'(acc);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // unit face normal of cross(b-a, c-a); returns 1 when degenerate
    task automatic face_normal(input longint a [3], input longint b [3],
                               input longint c [3], output longint n [3],
                               output bit degen);
        longint e1 [3];
        longint e2 [3];
        longint cr [3];
        longint m;
        longint unsigned sum, len, q;
        longint v;
        int s;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
            if (magnitude(e1[i]) > m) m = magnitude(e1[i]);
            if (magnitude(e2[i]) > m) m = magnitude(e2[i]);
        end
        s = 0;
        while ((m >>> s) >= (64'sd1 << 30)) s++;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = e1[i] >>> s;
            e2[i] = e2[i] >>> s;
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        n = '{0, 0, 0};
        m = 0;
        for (int i = 0; i < 3; i++) if (magnitude(cr[i]) > m) m = magnitude(cr[i]);
        degen = (m == 0);
        if (degen) return;
        s = 0;
        while ((m >>> s) >= (64'sd1 << 30)) s++;
        for (int i = 0; i < 3; i++) cr[i] = cr[i] >>> s;
        m = 0;
        for (int i = 0; i < 3; i++) if (magnitude(cr[i]) > m) m = magnitude(cr[i]);
        while (m < (64'sd1 << 29))
        begin
            m *= 2;
            for (int i = 0; i < 3; i++) cr[i] *= 2;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += longint'(cr[i] * cr[i]);
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((longint'(magnitude(cr[i])) << 14) + len / 2) / len;
            v = q;
            if (v > 16384) v = 16384;
            n[i] = cr[i] < 0 ? -v : v;
        end
    endtask

    function automatic vertex_result_t make_result(longint p [3], longint n [3],
                                                   status_t st, bit te, bit me);
        vertex_result_t r;
        r.x = p[0]; r.y = p[1]; r.z = p[2];
        r.nx = n[0]; r.ny = n[1]; r.nz = n[2];
        r.st = st; r.tri_end = te; r.mesh_fin = me;
        return r;
    endfunction

    // transform one vertex and queue the results it closes
    task automatic predict_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z, bit last);
        longint t [3];
        longint a [3];
        longint b [3];
        longint n [3];
        bit degen;
        status_t st;
        t[0] = apply_row(matrix_entry(REG_COL0_XY, 0), x, matrix_entry(REG_COL0Z_COL1X, 1), y,
                         matrix_entry(REG_COL2_XY, 0), z, matrix_entry(REG_COL2Z_TRANS_X, 1));
        t[1] = apply_row(matrix_entry(REG_COL0_XY, 1), x, matrix_entry(REG_COL1_YZ, 0), y,
                         matrix_entry(REG_COL2_XY, 1), z, matrix_entry(REG_TRANS_YZ, 0));
        t[2] = apply_row(matrix_entry(REG_COL0Z_COL1X, 0), x, matrix_entry(REG_COL1_YZ, 1), y,
                         matrix_entry(REG_COL2Z_TRANS_X, 0), z, matrix_entry(REG_TRANS_YZ, 1));
        n = '{0, 0, 0};
        if (corner_count < 2)
        begin
            pend_x[corner_count] = t[0];
            pend_y[corner_count] = t[1];
            pend_z[corner_count] = t[2];
            corner_count++;
            if (!last) return;
            corner_count = 0;
            expected_vertices.push_back(make_result(t, n, STATUS_INCOMPLETE, 1, 1));
            return;
        end
        corner_count = 0;
        a = '{pend_x[0], pend_y[0], pend_z[0]};
        b = '{pend_x[1], pend_y[1], pend_z[1]};
        face_normal(a, b, t, n, degen);
        st = degen ? STATUS_DEGEN : STATUS_OK;
        expected_vertices.push_back(make_result(a, n, st, 0, 0));
        expected_vertices.push_back(make_result(b, n, st, 0, 0));
        expected_vertices.push_back(make_result(t, n, st, 1, last));
    endtask

    // ---------------- drivers ----------------

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // offer one vertex; returns at a falling edge with valid possibly still high
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, bit last);
        int gap;
        in_valid  <= 1'b1;
        pos_x     <= x;
        pos_y     <= y;
        pos_z     <= z;
        mesh_last <= last;
        do @(posedge clk); while (!in_ready);
        predict_vertex(x, y, z, last);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_triangle(logic signed [31:0] v [9], bit last);
        send_vertex(v[0], v[1], v[2], 0);
        send_vertex(v[3], v[4], v[5], 0);
        send_vertex(v[6], v[7], v[8], last);
    endtask

    // drop valid, wait for every result, then let a pending vertex finish
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        matrix_regs[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1,
                               logic [CFG_W-1:0] r2, logic [CFG_W-1:0] r3,
                               logic [CFG_W-1:0] r4, logic [CFG_W-1:0] r5);
        write_reg(REG_COL0_XY, r0);
        write_reg(REG_COL0Z_COL1X, r1);
        write_reg(REG_COL1_YZ, r2);
        write_reg(REG_COL2_XY, r3);
        write_reg(REG_COL2Z_TRANS_X, r4);
        write_reg(REG_TRANS_YZ, r5);
    endtask

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endfunction

    function automatic logic [63:0] rand_pair();
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        return {32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000),
                32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000)};
    endfunction

    // ---------------- receiver and checker ----------------

    // hold out_ready low at random, with one long hold on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 0;
            end
            else if (no_gaps || $urandom_range(0, 99) < 70)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                  : $urandom_range(15, 60))
                    @(negedge clk);
            end
        end
    end

    // compare each accepted request with the oldest expectation
    always @(posedge clk)
    begin
        vertex_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected request: x=%0d y=%0d z=%0d status=%0d",
                             out_x, out_y, out_z, status);
            end
            else
            begin
                e = expected_vertices.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
                    norm_x !== e.nx || norm_y !== e.ny || norm_z !== e.nz ||
                    status !== e.st || triangle_end !== e.tri_end ||
                    mesh_end !== e.mesh_fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("expected pos %0d %0d %0d n %0d %0d %0d st %0d te %0d me %0d",
                                 e.x, e.y, e.z, e.nx, e.ny, e.nz, e.st, e.tri_end,
                                 e.mesh_fin);
                        $display("actual   pos %0d %0d %0d n %0d %0d %0d st %0d te %0d me %0d",
                                 out_x, out_y, out_z, norm_x, norm_y, norm_z, status,
                                 triangle_end, mesh_end);
                    end
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_identity_cases();
        logic signed [31:0] tri_v [9];
        // plain triangle in the xy plane, closing the mesh
        tri_v = '{0, 0, 0, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0};
        send_triangle(tri_v, 1);
        // field extremes
        tri_v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, -1, -1, 32'sh8000_0000};
        send_triangle(tri_v, 0);
        // collinear corners give a degenerate face
        tri_v = '{0, 0, 0, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000,
                  32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000};
        send_triangle(tri_v, 0);
        // all three corners identical
        tri_v = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
        send_triangle(tri_v, 1);
        // mesh ends after one corner, then after two
        send_vertex(32'sh0003_0000, -7, 1, 1);
        send_vertex(1, 2, 3, 0);
        send_vertex(-4, 32'sh7FFF_FFFF, 9, 1);
        drain();
    endtask

    task automatic test_matrix_settings();
        logic signed [31:0] tri_v [9];
        tri_v = '{32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, -32'sh0003_0000,
                  32'sh0001_0000, 32'sh0000_8000, 32'sh0000_2000, 32'sh0004_0000,
                  -32'sh0001_0000};
        // zero matrix collapses every corner onto the translation
        load_matrix(0, 0, 0, 0, 64'h0000_1234_0000_0000, 64'h8000_0000_7FFF_FFFF);
        send_triangle(tri_v, 0);
        drain();
        // largest positive entries saturate
        load_matrix({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                    {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}});
        send_triangle(tri_v, 1);
        drain();
        // most negative entries
        load_matrix({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                    {2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}});
        send_triangle(tri_v, 0);
        drain();
        // all ones: every entry is one lsb below zero, exercising rounding
        load_matrix('1, '1, '1, '1, '1, '1);
        send_triangle(tri_v, 0);
        drain();
        // rotation-like matrix with translation
        load_matrix(64'h0000_8000_0000_DDB4, 64'h0000_8000_0000_0000,
                    64'h0000_0000_0000_DDB4, 64'h0000_0000_0000_0000,
                    64'h0002_0000_0001_0000, 64'hFFFF_0000_0000_4000);
        send_triangle(tri_v, 1);
        drain();
    endtask

    task automatic test_backpressure();
        logic signed [31:0] tri_v [9];
        // hold the receiver while vertices keep coming
        hold_request = 1;
        for (int t = 0; t < 3; t++)
        begin
            foreach (tri_v[i]) tri_v[i] = rand_coord();
            send_triangle(tri_v, t == 2);
        end
        // pause the sender until everything is out
        drain();
    endtask

    task automatic test_random_meshes();
        logic signed [31:0] tri_v [9];
        int sent;
        int kind;
        sent = 0;
        while (sent < 100)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                drain();
                load_matrix(rand_pair(), rand_pair(), rand_pair(), rand_pair(),
                            rand_pair(), rand_pair());
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                // random triangles, some with a repeated corner; mesh often ends on the last one
                foreach (tri_v[i]) tri_v[i] = rand_coord();
                if (kind == 6)
                begin
                    tri_v[6] = tri_v[3]; tri_v[7] = tri_v[4]; tri_v[8] = tri_v[5];
                end
                send_triangle(tri_v, $urandom_range(0, 3) == 0);
                sent += 3;
            end
            else
            begin
                // short mesh that ends early
                send_vertex(rand_coord(), rand_coord(), rand_coord(), kind == 7);
                if (kind != 7)
                    send_vertex(rand_coord(), rand_coord(), rand_coord(), 1);
                sent += (kind == 7) ? 1 : 2;
            end
        end
        no_gaps = 0;
        drain();
    endtask

    // ---------------- sequence ----------------

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        mesh_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        hold_request = 0;
        no_gaps = 0;
        corner_count = 0;
        foreach (matrix_regs[i]) matrix_regs[i] = CFG_RESET[i];
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_identity_cases();
        test_matrix_settings();
        test_backpressure();
        test_random_meshes();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: triangle_transform_flat_normal.f
rtl/core/tfn_pkg.sv
rtl/core/tfn_mul.sv
rtl/core/tfn_sqrt.sv
rtl/core/tfn_div.sv
rtl/core/triangle_transform_flat_normal.sv
bench/triangle_transform_flat_normal_test.sv
